FILE: rtl/itp_pkg.sv
// Shared types, constants and character helpers for the integer text parser.
// No dependencies; compiled first.
package itp_pkg;

  // Width of the running character position; it saturates at all ones.
  localparam int OFFSET_BITS = 16;
  localparam int END_BITS    = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [5:0] RADIX_AUTO  = 6'd0;
  localparam logic [5:0] RADIX_OCT   = 6'd8;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] RADIX_HEX   = 6'd16;
  localparam logic [5:0] RADIX_RESET = RADIX_DEC;
  localparam logic [5:0] LETTER_BIAS = 6'd10;  // 'a' maps to 10

  typedef enum logic [5:0] {
    PH_SKIP   = 6'b000001,
    PH_START  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_X      = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } itp_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } itp_word_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } itp_digit_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Digit value 0..35 of an alphanumeric character, base not yet applied.
  function automatic itp_digit_t digit_raw(input logic [7:0] c);
    itp_digit_t d;
    d.ok  = 1'b1;
    d.val = 6'd0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d.val = 6'(c - CH_ZERO);
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      d.val = 6'(c - CH_LA) + LETTER_BIAS;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      d.val = 6'(c - CH_UA) + LETTER_BIAS;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/itp_if.sv
// Valid/ready channel interfaces for the character input and the result output.
// Uses no package items.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface itp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        negative;
  logic [15:0] end_offset;

  modport source (output valid, output value, output negative, output end_offset, input ready);
  modport sink (input valid, input value, input negative, input end_offset, output ready);
endinterface

FILE: rtl/itp_in_stage.sv
// Input register stage: captures one character word per handshake.
// Depends on itp_pkg and itp_in_if.
module itp_in_stage
  import itp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_in_if.sink     in_i,
  input  logic       take_i,
  output logic       word_valid_o,
  output itp_word_t  word_o
);

  logic      valid_q, valid_d;
  itp_word_t word_q;

  // Accept when empty or when the held word moves on this cycle.
  assign in_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      word_q.ch   <= in_i.ch;
      word_q.last <= in_i.last;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

FILE: rtl/itp_parse.sv
// Parse state, per-character step logic, radix register and result register.
// Depends on itp_pkg and itp_out_if.
module itp_parse
  import itp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       word_valid_i,
  input  itp_word_t  word_i,
  output logic       take_o,
  itp_out_if.source  out_o
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [31:0]            END_MAX = 32'((64'd1 << END_BITS) - 64'd1);

  logic [5:0]             radix_q;
  itp_phase_e             phase_q, phase_d;
  logic [63:0]            acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [5:0]             base_q, base_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, end_q, end_d;
  logic [OFFSET_BITS-1:0] pos_inc;

  logic        start_path, use_dig, dig_ok;
  logic [5:0]  start_base, base2;
  logic [63:0] mac;
  itp_digit_t  raw;
  logic [7:0]  c;

  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q;
  logic        negative_q;
  logic [15:0] end_offset_q;
  logic [31:0] end_ext;

  assign c       = word_i.ch;
  assign raw     = digit_raw(c);
  assign pos_inc = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

  // A word without a result always moves; a last word needs the result slot.
  assign take_o = word_valid_i && (!word_i.last || !out_valid_q || out_o.ready);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    base_d     = base_q;
    pos_d      = pos_q;
    end_d      = end_q;
    start_path = 1'b0;
    start_base = base_q;
    use_dig    = 1'b0;
    base2      = base_q;

    case (phase_q)
      PH_SKIP: begin
        base_d = radix_q;
        if (is_white(c)) begin
          pos_d = pos_inc;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          neg_d   = (c == CH_MINUS);
          pos_d   = pos_inc;
          phase_d = PH_START;
        end else begin
          start_path = 1'b1;
          start_base = radix_q;
        end
      end
      PH_START: begin
        start_path = 1'b1;
      end
      PH_ZERO: begin
        if ((c == CH_LX) || (c == CH_UX)) begin
          pos_d   = pos_inc;
          phase_d = PH_X;
        end else begin
          if (base_q == RADIX_AUTO) begin
            base2 = (raw.ok && (raw.val < RADIX_OCT)) ? RADIX_OCT : RADIX_DEC;
          end
          base_d  = base2;
          use_dig = 1'b1;
        end
      end
      PH_X: begin
        if (raw.ok && (raw.val < RADIX_HEX)) begin
          base2   = RADIX_HEX;
          base_d  = RADIX_HEX;
          use_dig = 1'b1;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DIGITS: begin
        use_dig = 1'b1;
      end
      default: begin
      end
    endcase

    if (start_path) begin
      if (((start_base == RADIX_AUTO) || (start_base == RADIX_HEX)) && (c == CH_ZERO)) begin
        // A leading zero may open a prefix; it counts as a digit already.
        acc_d   = 64'd0;
        pos_d   = pos_inc;
        end_d   = pos_inc;
        base_d  = start_base;
        phase_d = PH_ZERO;
      end else begin
        base2   = (start_base == RADIX_AUTO) ? RADIX_DEC : start_base;
        base_d  = base2;
        use_dig = 1'b1;
      end
    end

    dig_ok = raw.ok && (raw.val < base2);
    mac    = acc_q * {58'd0, base2} + {58'd0, raw.val};

    if (use_dig) begin
      if (dig_ok) begin
        acc_d   = mac;
        pos_d   = pos_inc;
        end_d   = pos_inc;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  assign end_ext = 32'(end_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o && word_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      phase_q     <= PH_SKIP;
      acc_q       <= 64'd0;
      neg_q       <= 1'b0;
      base_q      <= RADIX_AUTO;
      pos_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (take_o) begin
        if (word_i.last) begin
          // Return to the reset state for the next string; radix is kept.
          phase_q <= PH_SKIP;
          acc_q   <= 64'd0;
          neg_q   <= 1'b0;
          base_q  <= RADIX_AUTO;
          pos_q   <= '0;
          end_q   <= '0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          neg_q   <= neg_d;
          base_q  <= base_d;
          pos_q   <= pos_d;
          end_q   <= end_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && word_i.last) begin
      value_q      <= neg_d ? (64'd0 - acc_d) : acc_d;
      negative_q   <= neg_d;
      end_offset_q <= (end_ext > END_MAX) ? END_MAX[15:0] : end_ext[15:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value      = value_q;
  assign out_o.negative   = negative_q;
  assign out_o.end_offset = end_offset_q;

endmodule

FILE: rtl/integer_text_parser_unit.sv
// Top level of the streaming integer text parser.
// Depends on itp_pkg, itp_if, itp_in_stage and itp_parse.
//
// Usage:
//   in_i carries one character word per handshake (ch, last). Leading white
//   space is skipped, one sign is taken, then digits in the base held by the
//   radix register (0 = automatic, 0x/0X prefix and leading-zero octal).
//   out_o carries one result per string, on the word marked last: the value
//   (negated modulo 2^64 after a minus), the sign flag and the end offset.
//   cfg_we_i/cfg_wdata_i write the radix register; write it only while idle.
// Timing:
//   One word per cycle while out_o does not stall a last word. A word is held in
//   the input register and is parsed by the multiply-add step into the result
//   register, which raises out_o.valid when the last word is taken from it.
// Reset:
//   rst_ni clears the parse state to white-space skipping and sets radix 10.
// Stall:
//   While a result waits on out_o, words without last keep flowing; a last
//   word holds in the input register and in_i stalls until the result is taken.
module integer_text_parser_unit
  import itp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  itp_in_if.sink     in_i,
  itp_out_if.source  out_o
);

  logic      word_valid;
  logic      take;
  itp_word_t word;

  itp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  itp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .word_valid_i (word_valid),
    .word_i       (word),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

FILE: tb/sv/integer_text_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for integer_text_parser_unit: directed and random text
// over several radix settings, scored against an in-bench parse tracker.
// Depends on itp_pkg, itp_if and the parser RTL.
module integer_text_parser_unit_tb;
  import itp_pkg::*;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [63:0] value;
    logic        negative;
    logic [15:0] end_offset;
  } parse_out_t;

  // Tracks the parse of the accepted words and holds the values still due.
  class parse_tracker;
    logic [5:0]  radix;
    itp_phase_e  phase;
    logic [63:0] acc;
    logic        minus;
    logic [5:0]  base;
    logic [15:0] pos;
    logic [15:0] end_pos;
    parse_out_t  values_due[$];
    int          errors;
    int          checked;

    function new();
      radix   = RADIX_RESET;
      errors  = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      phase   = PH_SKIP;
      acc     = '0;
      minus   = 1'b0;
      base    = '0;
      pos     = '0;
      end_pos = '0;
    endfunction

    function void set_radix(logic [5:0] r);
      radix = r;
    endfunction

    function int pending();
      return values_due.size();
    endfunction

    function int char_digit(logic [7:0] c, logic [5:0] b);
      int d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        d = c - CH_LA + int'(LETTER_BIAS);
      end else if (c >= CH_UA && c <= CH_UZ) begin
        d = c - CH_UA + int'(LETTER_BIAS);
      end else begin
        return -1;
      end
      return (d < int'(b)) ? d : -1;
    endfunction

    // Saturate at all ones.
    function void bump();
      if (pos != '1) pos++;
    endfunction

    function void on_digit(logic [7:0] c);
      int d;
      d = char_digit(c, base);
      if (d < 0) begin
        phase = PH_DONE;
        return;
      end
      acc = acc * 64'(base) + 64'(d);
      bump();
      end_pos = pos;
    endfunction

    function void on_start(logic [7:0] c);
      if ((base == RADIX_AUTO || base == RADIX_HEX) && c == CH_ZERO) begin
        acc = '0;
        bump();
        end_pos = pos;
        phase = PH_ZERO;
        return;
      end
      if (base == RADIX_AUTO) base = RADIX_DEC;
      phase = PH_DIGITS;
      on_digit(c);
    endfunction

    function void on_zero(logic [7:0] c);
      if (c == CH_LX || c == CH_UX) begin
        bump();
        phase = PH_X;
        return;
      end
      if (base == RADIX_AUTO) base = (char_digit(c, RADIX_OCT) >= 0) ? RADIX_OCT : RADIX_DEC;
      phase = PH_DIGITS;
      on_digit(c);
    endfunction

    // A prefix counts only with a hex digit behind it.
    function void on_x(logic [7:0] c);
      if (char_digit(c, RADIX_HEX) >= 0) begin
        base = RADIX_HEX;
        phase = PH_DIGITS;
        on_digit(c);
      end else begin
        phase = PH_DONE;
      end
    endfunction

    function void on_skip(logic [7:0] c);
      base = radix;
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        bump();
        return;
      end
      if (c == CH_PLUS || c == CH_MINUS) begin
        minus = (c == CH_MINUS);
        bump();
        phase = PH_START;
        return;
      end
      on_start(c);
    endfunction

    function void char_in(logic [7:0] c, logic l);
      parse_out_t r;
      case (phase)
        PH_SKIP:   on_skip(c);
        PH_START:  on_start(c);
        PH_ZERO:   on_zero(c);
        PH_X:      on_x(c);
        PH_DIGITS: on_digit(c);
        default:   ;
      endcase
      if (l) begin
        r.value      = minus ? 64'd0 - acc : acc;
        r.negative   = minus;
        r.end_offset = end_pos;
        values_due.push_back(r);
        clear();
      end
    endfunction

    function void result_out(logic [63:0] v, logic n, logic [15:0] e);
      parse_out_t want;
      checked++;
      if (values_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h negative %b end_offset %0d", $time, v, n, e);
        return;
      end
      want = values_due.pop_front();
      if (want.value !== v || want.negative !== n || want.end_offset !== e) begin
        errors++;
        $display("%0t: mismatch expected %h/%b/%0d actual %h/%b/%0d", $time,
                 want.value, want.negative, want.end_offset, v, n, e);
      end
    endfunction
  endclass

  localparam int RANDOM_WORDS = 1250;
  localparam int LONG_HOLD    = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [5:0] cfg_wdata_i;

  itp_in_if  in_if();
  itp_out_if out_if();

  integer_text_parser_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  parse_tracker sb = new();

  int         items_sent = 0;
  int         burst_left = 0;
  int         writes = 0;
  int         hold_asks = 0;
  logic [5:0] radix_now = RADIX_RESET;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[integer_text_parser_unit] ERROR");
    $finish;
  end

  // Score every word and result at the edge that moves it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.char_in(in_if.ch, in_if.last);
      if (out_if.valid && out_if.ready) sb.result_out(out_if.value, out_if.negative,
                                                      out_if.end_offset);
    end
  end

  // Receiver: stall on rotating patterns; hold off for a long stretch on request.
  initial begin : receiver
    int          served;
    int          run;
    logic [15:0] pat;
    served = 0;
    run    = 0;
    pat    = '1;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && hold_asks != served) begin
        served = served + 1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (run == 0) begin
          run = $urandom_range(16, 96);
          case ($urandom_range(0, 2))
            0:       pat = '1;
            1:       pat = 16'($urandom) | 16'($urandom);
            default: pat = 16'($urandom);
          endcase
        end
        out_if.ready <= pat[0];
        pat = {pat[0], pat[15:1]};
        run--;
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= l;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_word(t[i], i == t.size() - 1);
  endtask

  // Drop valid, let the scorer see the final word, wait out every result.
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [5:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_radix(r);
    radix_now = r;
    writes++;
  endtask

  task automatic run_text(input logic [5:0] r, input text_t t);
    if (r != radix_now) begin
      settle();
      write_radix(r);
    end
    send_text(t);
  endtask

  function automatic text_t to_text(string s);
    text_t t;
    t = {};
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  // Random byte, often one that sits on a class boundary.
  function automatic logic [7:0] noise_char();
    logic [7:0] edges[20];
    edges = '{8'h00, 8'hff, CH_PLUS, CH_MINUS, CH_LX, CH_UX, CH_ZERO, CH_SPACE,
              8'h38, 8'h39, 8'h67, 8'h47, CH_LZ, CH_UZ, 8'h2f, 8'h3a, 8'h40, 8'h5b,
              8'h60, 8'h7b};
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return edges[$urandom_range(0, 19)];
  endfunction

  function automatic text_t make_text(logic [5:0] r);
    text_t t;
    int    n;
    int    eb;
    t = {};
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) t.push_back(noise_char());
      return t;
    end
    repeat ($urandom_range(0, 3)) begin
      t.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
    end
    case ($urandom_range(0, 3))
      0:       t.push_back(CH_MINUS);
      1:       t.push_back(CH_PLUS);
      default: ;
    endcase
    eb = (r == RADIX_AUTO) ? 10 : ((r > 36) ? 36 : int'(r));
    if ((r == RADIX_AUTO || r == RADIX_HEX) && $urandom_range(0, 2) == 0) begin
      t.push_back(CH_ZERO);
      t.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      eb = 16;
    end else if (r == RADIX_AUTO && $urandom_range(0, 3) == 0) begin
      t.push_back(CH_ZERO);
      eb = 8;
    end
    // Long runs wrap the accumulator.
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 26) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) t.push_back(digit_char($urandom_range(0, eb - 1)));
    if ($urandom_range(0, 99) < 30 || t.size() == 0) begin
      repeat ($urandom_range(1, 3)) t.push_back(noise_char());
    end
    return t;
  endfunction

  function automatic logic [5:0] pick_radix();
    logic [5:0] picks[10];
    picks = '{RADIX_AUTO, RADIX_AUTO, RADIX_DEC, RADIX_HEX, RADIX_OCT, 6'd2, 6'd36, 6'd1,
              6'd63, 6'd37};
    if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
    return picks[$urandom_range(0, 9)];
  endfunction

  initial begin : stimulus
    text_t      t;
    logic [5:0] r;
    int         goal;
    int         strings_left;
    bit         did_hold;
    bit         did_pause;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_if.valid  <= 1'b0;
    in_if.ch     <= '0;
    in_if.last   <= 1'b0;
    did_hold     = 1'b0;
    did_pause    = 1'b0;
    strings_left = 0;
    r            = RADIX_DEC;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_radix(RADIX_DEC);

    // Directed: signs, prefixes, automatic base, text end rules, odd radix values.
    run_text(RADIX_DEC, to_text("\t+7"));
    run_text(RADIX_DEC, to_text("-"));
    run_text(RADIX_AUTO, to_text("-0X1A"));
    run_text(RADIX_AUTO, to_text("0x"));
    run_text(RADIX_AUTO, to_text("08"));
    run_text(RADIX_AUTO, to_text("017"));
    t = {};
    t.push_back(8'h35);
    t.push_back(8'h00);
    t.push_back(8'hff);
    run_text(RADIX_AUTO, t);
    run_text(RADIX_HEX, to_text("0xg"));
    run_text(6'd36, to_text("Zz"));
    run_text(6'd1, to_text("01"));
    run_text(6'd63, to_text("z"));

    goal = items_sent + RANDOM_WORDS;
    while (items_sent < goal) begin
      if (strings_left == 0) begin
        strings_left = $urandom_range(5, 20);
        r = pick_radix();
      end
      if (!did_hold && items_sent > goal - 850) begin
        // Receiver holds off while short strings keep coming: the block fills up.
        did_hold = 1'b1;
        hold_asks <= hold_asks + 1;
        repeat (12) send_text(to_text("1"));
      end
      if (!did_pause && items_sent > goal - 450) begin
        did_pause = 1'b1;
        settle();
      end
      run_text(r, make_text(r));
      strings_left--;
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d parse results from %0d words over %0d radix writes,",
             sb.checked, items_sent, writes);
    $display("covering prefixes, automatic base, signs, wraparound and receiver stalls.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[integer_text_parser_unit] OK");
    end else begin
      $display("[integer_text_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_in_stage.sv
rtl/itp_parse.sv
rtl/integer_text_parser_unit.sv
tb/sv/integer_text_parser_unit_tb.sv
